@@ src/playfair_encryptor_macros.svh @@
// assertion macros for the playfair encryptor
// no dependencies; included by modules that carry concurrent checks
`ifndef PLAYFAIR_ENCRYPTOR_MACROS_SVH
`define PLAYFAIR_ENCRYPTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PFE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PFE_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define PFE_ASSERT(lbl, clk, rstn, prop, msg)
`define PFE_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

@@ src/pfe_pkg.sv @@
// shared types, constants and helpers for the playfair encryptor
// no dependencies; imported by every module of the block
package pfe_pkg;

  typedef enum logic [1:0] {
    CMD_KEY    = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  localparam logic [4:0] IDX_I       = 5'd8;
  localparam logic [4:0] IDX_J       = 5'd9;
  localparam logic [4:0] IDX_X       = 5'd23;
  localparam logic [4:0] IDX_Z       = 5'd25;
  localparam logic [4:0] NUM_CELLS   = 5'd25;
  localparam logic [4:0] LAST_LETTER = 5'd25;
  localparam logic [2:0] GRID_LAST   = 3'd4;
  localparam logic [6:0] ASCII_A     = 7'd65;

  typedef struct packed {
    logic       ok;
    logic [4:0] idx;
  } letter_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  typedef struct packed {
    logic key_place;
    logic fill_start;
    logic fill_step;
    logic set_ready;
    logic pend_load;
    logic pend_clear;
    logic pair_start;
    logic cell_read;
  } dp_cmd_t;

  typedef struct packed {
    logic key_ready;
    logic pend_valid;
    logic in_letter;
    logic fill_done;
  } dp_stat_t;

  typedef struct packed {
    logic push_pair;
    logic push_mark;
  } oq_cmd_t;

  typedef struct packed {
    logic [6:0] letter;
    logic       valid;
    logic       last;
  } res_t;

  function automatic letter_t decode_char(input logic [7:0] c);
    logic [7:0] u;
    letter_t    r;
    u     = (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
    r.ok  = (u >= 8'd65 && u <= 8'd90);
    r.idx = 5'(u - 8'd65);
    return r;
  endfunction

  function automatic logic [2:0] inc5(input logic [2:0] x);
    return (x == GRID_LAST) ? 3'd0 : x + 3'd1;
  endfunction

  function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
    return 5'({row, 2'b00}) + 5'(row) + 5'(col);
  endfunction

endpackage

@@ src/pfe_outq.sv @@
// two-entry result queue between the datapath and the output stream
// depends on pfe_pkg
module pfe_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfe_pkg::oq_cmd_t cmd_i,
  input  logic [6:0]      letter0_i,
  input  logic [6:0]      letter1_i,
  input  logic            end_i,
  input  logic            ready_i,
  output logic            valid_o,
  output pfe_pkg::res_t   res_o,
  output logic            empty_o
);
  import pfe_pkg::*;

  logic [1:0] cnt_q;
  res_t       slot0_q, slot1_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign empty_o = (cnt_q == 2'd0);
  assign pop     = valid_o & ready_i;
  assign res_o   = slot0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (cmd_i.push_pair) begin
      cnt_q <= 2'd2;
    end else if (cmd_i.push_mark) begin
      cnt_q <= 2'd1;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_pair) begin
      slot0_q <= '{letter: letter0_i, valid: 1'b1, last: 1'b0};
      slot1_q <= '{letter: letter1_i, valid: 1'b1, last: end_i};
    end else if (cmd_i.push_mark) begin
      slot0_q <= '{letter: 7'd0, valid: 1'b0, last: 1'b1};
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

@@ src/pfe_dpath.sv @@
// datapath: key square and letter position memories, used set, pending letter
// depends on pfe_pkg; driven by pfe_ctrl commands
module pfe_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        char_i,
  input  pfe_pkg::cmd_e     cmd_i,
  input  pfe_pkg::dp_cmd_t  ctl_i,
  output pfe_pkg::dp_stat_t stat_o,
  output logic [6:0]        letter0_o,
  output logic [6:0]        letter1_o,
  output logic              end_o
);
  import pfe_pkg::*;

  logic [4:0] sq_mem [NUM_CELLS];
  pos_t       pos_mem [LAST_LETTER + 5'd1];

  logic [25:0] used_q;
  logic [4:0]  fill_q, fill_k_q, pend_q;
  logic [2:0]  row_q, col_q;
  logic        ready_q, pend_vld_q, end_q;
  pos_t        pos0_q, pos1_q;
  logic [4:0]  sq0_q, sq1_q;

  letter_t    dec;
  logic [4:0] txt_idx, place_idx, b_idx, sq_a0, sq_a1;
  logic       place_we, same, is_end;

  always_comb begin
    dec       = decode_char(char_i);
    txt_idx   = (dec.idx == IDX_J) ? IDX_I : dec.idx;
    place_idx = ctl_i.fill_step ? fill_k_q : dec.idx;
    place_we  = ((ctl_i.key_place & dec.ok) | ctl_i.fill_step)
                & (fill_q < NUM_CELLS) & !used_q[place_idx];
    same      = (txt_idx == pend_q);
    is_end    = (cmd_i == CMD_END);
    b_idx     = is_end ? IDX_Z : (same ? IDX_X : txt_idx);
    if (pos0_q.row == pos1_q.row) begin
      sq_a0 = cell_addr(pos0_q.row, inc5(pos0_q.col));
      sq_a1 = cell_addr(pos1_q.row, inc5(pos1_q.col));
    end else if (pos0_q.col == pos1_q.col) begin
      sq_a0 = cell_addr(inc5(pos0_q.row), pos0_q.col);
      sq_a1 = cell_addr(inc5(pos1_q.row), pos1_q.col);
    end else begin
      sq_a0 = cell_addr(pos0_q.row, pos1_q.col);
      sq_a1 = cell_addr(pos1_q.row, pos0_q.col);
    end
  end

  // memories and read data
  always_ff @(posedge clk_i) begin
    if (place_we) begin
      sq_mem[fill_q]     <= place_idx;
      pos_mem[place_idx] <= '{row: row_q, col: col_q};
    end
    if (ctl_i.pair_start) begin
      pos0_q <= pos_mem[pend_q];
      pos1_q <= pos_mem[b_idx];
      end_q  <= is_end;
    end
    if (ctl_i.cell_read) begin
      sq0_q <= sq_mem[sq_a0];
      sq1_q <= sq_mem[sq_a1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= 26'd1 << IDX_J;
      fill_q     <= 5'd0;
      row_q      <= 3'd0;
      col_q      <= 3'd0;
      fill_k_q   <= 5'd0;
      ready_q    <= 1'b0;
      pend_q     <= 5'd0;
      pend_vld_q <= 1'b0;
    end else begin
      if (place_we) begin
        used_q[place_idx] <= 1'b1;
        fill_q            <= fill_q + 5'd1;
        col_q             <= inc5(col_q);
        if (col_q == GRID_LAST) begin
          row_q <= row_q + 3'd1;
        end
      end
      if (ctl_i.fill_start) begin
        fill_k_q <= 5'd0;
      end else if (ctl_i.fill_step) begin
        fill_k_q <= fill_k_q + 5'd1;
      end
      if (ctl_i.set_ready) begin
        ready_q <= 1'b1;
      end
      if (ctl_i.pend_load) begin
        pend_q     <= txt_idx;
        pend_vld_q <= 1'b1;
      end else if (ctl_i.pend_clear || (ctl_i.pair_start && is_end)) begin
        pend_q     <= 5'd0;
        pend_vld_q <= 1'b0;
      end else if (ctl_i.pair_start && !same) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  assign stat_o.key_ready  = ready_q;
  assign stat_o.pend_valid = pend_vld_q;
  assign stat_o.in_letter  = dec.ok;
  assign stat_o.fill_done  = (fill_k_q == LAST_LETTER);

  assign letter0_o = 7'(sq0_q) + ASCII_A;
  assign letter1_o = 7'(sq1_q) + ASCII_A;
  assign end_o     = end_q;

endmodule

@@ src/pfe_ctrl.sv @@
// controller state machine: sequences key fill, pair lookups and result pushes
// depends on pfe_pkg and playfair_encryptor_macros.svh
`include "playfair_encryptor_macros.svh"

module pfe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  pfe_pkg::cmd_e     in_cmd_i,
  input  pfe_pkg::dp_stat_t stat_i,
  input  logic              oq_empty_i,
  output logic              in_ready_o,
  output pfe_pkg::dp_cmd_t  dp_cmd_o,
  output pfe_pkg::oq_cmd_t  oq_cmd_o
);
  import pfe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FILL = 5'b00010,
    S_POS  = 5'b00100,
    S_CELL = 5'b01000,
    S_MARK = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i & in_ready_o;

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    oq_cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (in_cmd_i)
            CMD_KEY: begin
              dp_cmd_o.key_place = !stat_i.key_ready;
            end
            CMD_FINISH: begin
              if (!stat_i.key_ready) begin
                dp_cmd_o.fill_start = 1'b1;
                state_d             = S_FILL;
              end
            end
            CMD_TEXT: begin
              if (stat_i.key_ready && stat_i.in_letter) begin
                if (!stat_i.pend_valid) begin
                  dp_cmd_o.pend_load = 1'b1;
                end else begin
                  dp_cmd_o.pair_start = 1'b1;
                  state_d             = S_POS;
                end
              end
            end
            CMD_END: begin
              if (stat_i.key_ready && stat_i.pend_valid) begin
                dp_cmd_o.pair_start = 1'b1;
                state_d             = S_POS;
              end else begin
                dp_cmd_o.pend_clear = 1'b1;
                state_d             = S_MARK;
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        dp_cmd_o.fill_step = 1'b1;
        if (stat_i.fill_done) begin
          dp_cmd_o.set_ready = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_POS: begin
        dp_cmd_o.cell_read = 1'b1;
        state_d            = S_CELL;
      end
      S_CELL: begin
        if (oq_empty_i) begin
          oq_cmd_o.push_pair = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_MARK: begin
        if (oq_empty_i) begin
          oq_cmd_o.push_mark = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PFE_ASSERT(a_push_needs_empty, clk_i, rst_ni, (oq_cmd_o.push_pair || oq_cmd_o.push_mark) |-> oq_empty_i, "result push while queue busy")
  `PFE_ASSERT(a_pair_to_lookup, clk_i, rst_ni, dp_cmd_o.pair_start |=> (state_q == S_POS), "pair start did not enter lookup")
  `PFE_ASSERT_NEVER(a_fill_after_ready, clk_i, rst_ni, (state_q == S_FILL) && stat_i.key_ready, "key fill after square ready")

endmodule

@@ src/playfair_encryptor.sv @@
// top level of the playfair encryptor: stream ports, controller, datapath, result queue
// depends on pfe_pkg, pfe_ctrl, pfe_dpath, pfe_outq
//
// channel  dir  tdata                tuser               tlast
// s_axis   in   char_code[7:0]       cmd[1:0]            -
// m_axis   out  out_letter[6:0], 0   letter_valid        last
//
// key character, finish when ready, plaintext with no pair formed: idle state only
// bare end marker: mark state; finish key: fill state, one letter checked per cycle
// plaintext pair or end with pending letter: position read then square read
// a two-entry queue drains one result per ready cycle; a push waits until it is empty
// reset clears the used set, fill position, key ready and pending letter
module playfair_encryptor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // char_code[7:0]
  input  logic [1:0] s_axis_tuser_i,  // cmd[1:0]
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // out_letter[6:0], zero pad[7]
  output logic       m_axis_tuser_o,  // letter_valid
  output logic       m_axis_tlast_o
);
  import pfe_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_stat_t   dp_stat;
  oq_cmd_t    oq_cmd;
  res_t       res;
  logic       oq_empty, pair_end;
  logic [6:0] letter0, letter1;
  cmd_e       cmd;

  assign cmd = cmd_e'(s_axis_tuser_i);

  pfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (cmd),
    .stat_i     (dp_stat),
    .oq_empty_i (oq_empty),
    .in_ready_o (s_axis_tready_o),
    .dp_cmd_o   (dp_cmd),
    .oq_cmd_o   (oq_cmd)
  );

  pfe_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_i    (s_axis_tdata_i),
    .cmd_i     (cmd),
    .ctl_i     (dp_cmd),
    .stat_o    (dp_stat),
    .letter0_o (letter0),
    .letter1_o (letter1),
    .end_o     (pair_end)
  );

  pfe_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (oq_cmd),
    .letter0_i (letter0),
    .letter1_i (letter1),
    .end_i     (pair_end),
    .ready_i   (m_axis_tready_i),
    .valid_o   (m_axis_tvalid_o),
    .res_o     (res),
    .empty_o   (oq_empty)
  );

  assign m_axis_tdata_o = {1'b0, res.letter};
  assign m_axis_tuser_o = res.valid;
  assign m_axis_tlast_o = res.last;

endmodule

@@ bench/tb.sv @@
// self-checking bench for playfair_encryptor: builds one key square, then streams plaintext
// depends on pfe_pkg and the playfair_encryptor rtl; a local predictor supplies expected ciphertext
`timescale 1ns / 1ps

module tb;
  import pfe_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;  // char_code[7:0]
  logic [1:0] s_axis_tuser_i;  // cmd[1:0]
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;  // out_letter[6:0], zero pad[7]
  logic       m_axis_tuser_o;  // letter_valid
  logic       m_axis_tlast_o;

  playfair_encryptor i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [4:0]  square [25];
  logic [25:0] placed_mask;
  int unsigned next_cell;
  bit          square_done;
  logic [4:0]  held_letter;
  bit          held_valid;
  res_t        cipher_q[$];
  res_t        head;

  int unsigned errors;
  bit          gaps_on;
  bit          stalls_on;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
    errors++;
  endtask

  function automatic bit letter_of(input logic [7:0] code, output logic [4:0] idx);
    logic [7:0] upper;
    upper = code;
    if (code inside {[8'd97:8'd122]}) upper = code & 8'hDF;
    idx = 5'(upper - 8'd65);
    return upper inside {[8'd65:8'd90]};
  endfunction

  function automatic void place_key_letter(input logic [4:0] idx);
    if (next_cell < 25 && !placed_mask[idx]) begin
      square[next_cell] = idx;
      placed_mask[idx] = 1'b1;
      next_cell++;
    end
  endfunction

  function automatic void find_cell(input logic [4:0] idx, output int row, output int col);
    row = 0;
    col = 0;
    for (int k = 24; k >= 0; k--) begin
      if (square[k] == idx) begin
        row = k / 5;
        col = k % 5;
      end
    end
  endfunction

  function automatic void cipher_pair(input logic [4:0] a, input logic [4:0] b,
                                      input bit mark_last);
    int         r1, c1, r2, c2;
    logic [4:0] e1, e2;
    find_cell(a, r1, c1);
    find_cell(b, r2, c2);
    if (r1 == r2) begin
      e1 = square[r1 * 5 + (c1 + 1) % 5];
      e2 = square[r2 * 5 + (c2 + 1) % 5];
    end else if (c1 == c2) begin
      e1 = square[((r1 + 1) % 5) * 5 + c1];
      e2 = square[((r2 + 1) % 5) * 5 + c2];
    end else begin
      e1 = square[r1 * 5 + c2];
      e2 = square[r2 * 5 + c1];
    end
    cipher_q.push_back('{letter: ASCII_A + 7'(e1), valid: 1'b1, last: 1'b0});
    cipher_q.push_back('{letter: ASCII_A + 7'(e2), valid: 1'b1, last: mark_last});
  endfunction

  function automatic void predict_cipher(input cmd_e cmd, input logic [7:0] code);
    logic [4:0] idx;
    bit         is_letter;
    is_letter = letter_of(code, idx);
    case (cmd)
      CMD_KEY: begin
        if (!square_done && is_letter) place_key_letter(idx);
      end
      CMD_FINISH: begin
        if (!square_done) begin
          for (int k = 0; k < 26; k++) place_key_letter(5'(k));
          square_done = 1'b1;
        end
      end
      CMD_TEXT: begin
        if (square_done && is_letter) begin
          if (idx == IDX_J) idx = IDX_I;
          if (!held_valid) begin
            held_letter = idx;
            held_valid = 1'b1;
          end else if (idx == held_letter) begin
            cipher_pair(held_letter, IDX_X, 1'b0);
          end else begin
            cipher_pair(held_letter, idx, 1'b0);
            held_valid = 1'b0;
          end
        end
      end
      default: begin
        if (square_done && held_valid) cipher_pair(held_letter, IDX_Z, 1'b1);
        else cipher_q.push_back('{letter: 7'd0, valid: 1'b0, last: 1'b1});
        held_valid = 1'b0;
        held_letter = 5'd0;
      end
    endcase
  endfunction

  // leaves tvalid high after the transaction so back-to-back items need one assignment per step
  task automatic send_item(input cmd_e cmd, input logic [7:0] code);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= code;
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_cipher(cmd, code);
  endtask

  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] any_letter();
    logic [7:0] code;
    code = 8'd65 + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) code = code | 8'h20;
    return code;
  endfunction

  task automatic test_before_key();
    send_item(CMD_TEXT, "A");
    send_item(CMD_END, 8'h00);
  endtask

  task automatic test_key_build();
    int unsigned extra;
    send_item(CMD_KEY, "p");
    send_item(CMD_KEY, "L");
    send_item(CMD_KEY, "J");
    send_item(CMD_KEY, "l");
    send_item(CMD_KEY, "#");
    send_item(CMD_KEY, 8'hFF);
    send_item(CMD_KEY, 8'hE1);
    // sometimes long enough to fill the whole square before finish
    extra = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(0, 20);
    repeat (extra) begin
      if ($urandom_range(0, 4) == 0) send_item(CMD_KEY, 8'($urandom_range(0, 255)));
      else send_item(CMD_KEY, any_letter());
    end
    send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
    send_item(CMD_KEY, "Q");
    send_item(CMD_FINISH, 8'h00);
  endtask

  task automatic test_directed_text();
    send_item(CMD_TEXT, "H");
    send_item(CMD_TEXT, "i");
    send_item(CMD_TEXT, "L");
    send_item(CMD_TEXT, "L");
    send_item(CMD_TEXT, "l");
    send_item(CMD_TEXT, "I");
    send_item(CMD_TEXT, "J");
    send_item(CMD_END, 8'hFF);
    send_item(CMD_TEXT, "X");
    send_item(CMD_TEXT, "x");
    send_item(CMD_END, 8'h00);
    send_item(CMD_TEXT, "Z");
    send_item(CMD_END, 8'h00);
    send_item(CMD_TEXT, "!");
    send_item(CMD_END, 8'h00);
    wait_drain();
  endtask

  task automatic test_random_text(input int unsigned target);
    int unsigned counted;
    int unsigned pick;
    logic [7:0]  code;
    logic [7:0]  prev_code;
    logic [4:0]  idx;
    cmd_e        cmd;
    counted   = 0;
    prev_code = "A";
    while (counted < target) begin
      if (counted % 100 == 0) begin
        gaps_on   = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      if (counted + 150 >= target) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      cmd  = CMD_TEXT;
      if (pick < 55) code = any_letter();
      else if (pick < 70) code = prev_code ^ (8'($urandom_range(0, 1)) << 5);
      else if (pick < 78) begin
        case ($urandom_range(0, 3))
          0: code = "X";
          1: code = "Z";
          2: code = "I";
          default: code = "j";
        endcase
      end else if (pick < 84) code = 8'($urandom_range(0, 255));
      else if (pick < 92) begin
        cmd  = CMD_END;
        code = 8'($urandom_range(0, 255));
      end else if (pick < 96) begin
        cmd  = CMD_KEY;
        code = 8'($urandom_range(0, 255));
      end else begin
        cmd  = CMD_FINISH;
        code = 8'($urandom_range(0, 255));
      end
      send_item(cmd, code);
      counted++;
      if (cmd == CMD_TEXT && letter_of(code, idx)) prev_code = code;
    end
    wait_drain();
  endtask

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected result transaction", 0, m_axis_tdata_o);
      end else begin
        head = cipher_q.pop_front();
        if (m_axis_tdata_o !== {1'b0, head.letter})
          report_mismatch("out_letter", {1'b0, head.letter}, m_axis_tdata_o);
        if (m_axis_tuser_o !== head.valid)
          report_mismatch("letter_valid", head.valid, m_axis_tuser_o);
        if (m_axis_tlast_o !== head.last)
          report_mismatch("last", head.last, m_axis_tlast_o);
      end
    end
  end

  // result side back-pressure
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    #1000000;
    $display("playfair_encryptor test failed");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tuser_i  = CMD_KEY;
    errors          = 0;
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    placed_mask     = 26'd0;
    placed_mask[IDX_J] = 1'b1;
    next_cell       = 0;
    square_done     = 1'b0;
    held_letter     = 5'd0;
    held_valid      = 1'b0;
    for (int k = 0; k < 25; k++) square[k] = 5'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_key();
    test_key_build();
    test_directed_text();
    test_random_text(1050);

    repeat (40) @(posedge clk_i);
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("playfair_encryptor test passed");
    end else begin
      $display("playfair_encryptor test failed");
    end
    $finish;
  end

endmodule
